// ===== src/gdad_pkg.sv =====
package gdad_pkg;

    localparam int YearW     = 14;
    localparam int MonW      = 4;
    localparam int DayW      = 5;
    localparam int OffW      = 17;
    localparam int MaxOffset = 65535;
    localparam int CntW      = $clog2(MaxOffset + 1);

    localparam logic [YearW-1:0] YearMin = YearW'(1);
    localparam logic [YearW-1:0] YearMax = YearW'(9999);
    localparam logic [YearW-1:0] Century = YearW'(100);
    localparam logic [6:0]       LastYy  = 7'd99;
    localparam logic [MonW-1:0]  MonJan  = MonW'(1);
    localparam logic [MonW-1:0]  MonFeb  = MonW'(2);
    localparam logic [MonW-1:0]  MonOct  = MonW'(10);
    localparam logic [MonW-1:0]  MonDec  = MonW'(12);
    localparam logic [DayW-1:0]  DayFirst = DayW'(1);
    localparam logic [DayW-1:0]  DayLast  = DayW'(31);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_STEP
    } state_t;

    // yy: year mod 100, cc: (year / 100) mod 4
    function automatic logic leap_year(input logic [6:0] yy, input logic [1:0] cc,
                                       input logic [1:0] y_lo);
        logic lp;
        if (yy == 7'd0)
            lp = (cc == 2'd0);
        else
            lp = (y_lo == 2'd0);
        return lp;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] mon,
                                                   input logic leap);
        logic [DayW-1:0] len;
        case (mon) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
            4'd2:    len = leap ? DayW'(29) : DayW'(28);
            default: len = DayW'(30);
        endcase
        return len;
    endfunction

endpackage

// ===== src/gregorian_date_add_days.sv =====
// Channel | Dir | Bits          | Contents (lowest bits first)
// s_axis  | in  | tdata[39:0]   | start_year 14, start_month 4, start_day 5, day_offset 17 (signed)
// m_axis  | out | tdata[23:0]   | result_year 14, result_month 4, result_day 5, pad 1
//         |     | tuser[1:0]    | is_october_first, range_error
//
// One request is accepted, then a mod-100 pass runs on the year (one subtract of
// 100 per cycle), then the date steps one day per cycle through the offset
// (|offset| clamped to 65535) until the count runs out or a range error stops it.
// The single day incrementer/decrementer does all of the stepping.
// Reset (rst_n low, async) idles the sequencer and drops m_axis_tvalid.
// A finished result sits in the output register; a new request is accepted meanwhile.
// A request that finishes while the output is still full waits in the step state.
module gregorian_date_add_days (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // start_year, start_month, start_day, day_offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // result_year, result_month, result_day, zero pad
    output logic [1:0]  m_axis_tuser    // is_october_first, range_error
);

    localparam int YW = gdad_pkg::YearW;
    localparam int MW = gdad_pkg::MonW;
    localparam int DW = gdad_pkg::DayW;
    localparam int OW = gdad_pkg::OffW;
    localparam int CW = gdad_pkg::CntW;

    // unpack request
    logic [YW-1:0] in_year;
    logic [MW-1:0] in_mon;
    logic [DW-1:0] in_day;
    logic [OW-1:0] in_off;
    logic [OW-1:0] off_mag;
    logic [CW-1:0] cnt_init;

    assign in_year = s_axis_tdata[YW-1:0];
    assign in_mon  = s_axis_tdata[YW+MW-1:YW];
    assign in_day  = s_axis_tdata[YW+MW+DW-1:YW+MW];
    assign in_off  = s_axis_tdata[YW+MW+DW+OW-1:YW+MW+DW];

    // magnitude of the offset, clamped to the largest supported step count
    assign off_mag  = in_off[OW-1] ? (~in_off + OW'(1)) : in_off;
    assign cnt_init = (in_off[OW-1] && off_mag == '0) || (off_mag > OW'(gdad_pkg::MaxOffset))
                      ? CW'(gdad_pkg::MaxOffset) : off_mag[CW-1:0];

    gdad_pkg::state_t state_reg, state_next;

    logic          out_valid_reg, out_valid_next;
    logic [YW-1:0] year_reg, year_next;
    logic [MW-1:0] mon_reg, mon_next;
    logic [DW-1:0] day_reg, day_next;
    logic [YW-1:0] org_year_reg, org_year_next;
    logic [MW-1:0] org_mon_reg, org_mon_next;
    logic [DW-1:0] org_day_reg, org_day_next;
    logic [YW-1:0] ymod_reg, ymod_next;     // remainder during mod pass, year mod 100 after
    logic [1:0]    cent_reg, cent_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          err_reg, err_next;
    logic [YW-1:0] oyear_reg, oyear_next;
    logic [MW-1:0] omon_reg, omon_next;
    logic [DW-1:0] oday_reg, oday_next;
    logic          oerr_reg, oerr_next;

    logic          leap;
    logic [DW-1:0] cur_len;
    logic [DW-1:0] prev_len;
    logic          start_ok;
    logic          mod_done;
    logic          step_done;
    logic          out_free;
    logic          in_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign mod_done = ymod_reg < gdad_pkg::Century;
    assign step_done = err_reg || (cnt_reg == '0);

    assign leap     = gdad_pkg::leap_year(ymod_reg[6:0], cent_reg, year_reg[1:0]);
    assign cur_len  = gdad_pkg::month_len(mon_reg, leap);
    assign prev_len = gdad_pkg::month_len(mon_reg - MW'(1), leap);

    assign start_ok = (year_reg >= gdad_pkg::YearMin) && (year_reg <= gdad_pkg::YearMax)
                   && (mon_reg >= gdad_pkg::MonJan) && (mon_reg <= gdad_pkg::MonDec)
                   && (day_reg >= gdad_pkg::DayFirst) && (day_reg <= cur_len);

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdad_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = gdad_pkg::ST_MOD;
            end
            gdad_pkg::ST_MOD:
            begin
                if (mod_done)
                    state_next = gdad_pkg::ST_STEP;
            end
            gdad_pkg::ST_STEP:
            begin
                if (step_done && out_free)
                    state_next = gdad_pkg::ST_IDLE;
            end
            default: state_next = gdad_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = (state_reg == gdad_pkg::ST_IDLE);
    end

    // datapath: shared day stepper and mod-100 subtractor
    always_comb
    begin
        year_next     = year_reg;
        mon_next      = mon_reg;
        day_next      = day_reg;
        org_year_next = org_year_reg;
        org_mon_next  = org_mon_reg;
        org_day_next  = org_day_reg;
        ymod_next     = ymod_reg;
        cent_next     = cent_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        err_next      = err_reg;
        oyear_next    = oyear_reg;
        omon_next     = omon_reg;
        oday_next     = oday_reg;
        oerr_next     = oerr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        case (state_reg)
            gdad_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    year_next     = in_year;
                    mon_next      = in_mon;
                    day_next      = in_day;
                    org_year_next = in_year;
                    org_mon_next  = in_mon;
                    org_day_next  = in_day;
                    ymod_next     = in_year;
                    cent_next     = 2'd0;
                    cnt_next      = cnt_init;
                    neg_next      = in_off[OW-1];
                    err_next      = 1'b0;
                end
            end
            gdad_pkg::ST_MOD:
            begin
                if (!mod_done)
                begin
                    ymod_next = ymod_reg - gdad_pkg::Century;
                    cent_next = cent_reg + 2'd1;
                end
                else
                begin
                    err_next = !start_ok;
                end
            end
            gdad_pkg::ST_STEP:
            begin
                if (step_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        oerr_next      = err_reg;
                        oyear_next     = err_reg ? org_year_reg : year_reg;
                        omon_next      = err_reg ? org_mon_reg : mon_reg;
                        oday_next      = err_reg ? org_day_reg : day_reg;
                    end
                end
                else if (!neg_reg)
                begin
                    // one day forward
                    if (day_reg < cur_len)
                        day_next = day_reg + DW'(1);
                    else if (mon_reg < gdad_pkg::MonDec)
                    begin
                        day_next = gdad_pkg::DayFirst;
                        mon_next = mon_reg + MW'(1);
                    end
                    else if (year_reg == gdad_pkg::YearMax)
                        err_next = 1'b1;
                    else
                    begin
                        day_next  = gdad_pkg::DayFirst;
                        mon_next  = gdad_pkg::MonJan;
                        year_next = year_reg + YW'(1);
                        if (ymod_reg[6:0] == gdad_pkg::LastYy)
                        begin
                            ymod_next = '0;
                            cent_next = cent_reg + 2'd1;
                        end
                        else
                            ymod_next = ymod_reg + YW'(1);
                    end
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    // one day back
                    if (day_reg > gdad_pkg::DayFirst)
                        day_next = day_reg - DW'(1);
                    else if (mon_reg > gdad_pkg::MonJan)
                    begin
                        mon_next = mon_reg - MW'(1);
                        day_next = prev_len;
                    end
                    else if (year_reg == gdad_pkg::YearMin)
                        err_next = 1'b1;
                    else
                    begin
                        day_next  = gdad_pkg::DayLast;
                        mon_next  = gdad_pkg::MonDec;
                        year_next = year_reg - YW'(1);
                        if (ymod_reg[6:0] == 7'd0)
                        begin
                            ymod_next = YW'(gdad_pkg::LastYy);
                            cent_next = cent_reg - 2'd1;
                        end
                        else
                            ymod_next = ymod_reg - YW'(1);
                    end
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg     <= year_next;
        mon_reg      <= mon_next;
        day_reg      <= day_next;
        org_year_reg <= org_year_next;
        org_mon_reg  <= org_mon_next;
        org_day_reg  <= org_day_next;
        ymod_reg     <= ymod_next;
        cent_reg     <= cent_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        err_reg      <= err_next;
        oyear_reg    <= oyear_next;
        omon_reg     <= omon_next;
        oday_reg     <= oday_next;
        oerr_reg     <= oerr_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, oday_reg, omon_reg, oyear_reg};
    assign m_axis_tuser  = {oerr_reg,
                            (omon_reg == gdad_pkg::MonOct) && (oday_reg == gdad_pkg::DayFirst)};

    // an accepted request always starts with the mod-100 pass
    a_fire_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == gdad_pkg::ST_MOD)
        else $error("request did not enter mod pass");

    // stepping keeps the year-mod-100 tracker in range
    a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdad_pkg::ST_STEP) |-> ymod_reg < gdad_pkg::Century)
        else $error("year mod 100 tracker out of range");

    // a good result has a month in 1..12 and a day of at least 1
    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |->
            (m_axis_tdata[17:14] >= gdad_pkg::MonJan && m_axis_tdata[17:14] <= gdad_pkg::MonDec
             && m_axis_tdata[22:18] >= gdad_pkg::DayFirst))
        else $error("result date out of range");

    // each stepping cycle with work left consumes one day
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdad_pkg::ST_STEP && !step_done) |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("day counter did not advance");

endmodule

// ===== bench/gdad_checker.sv =====
`timescale 1ns / 1ps

module gdad_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // start_year, start_month, start_day, day_offset
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // result_year, result_month, result_day, zero pad
    input  logic [1:0]  m_axis_tuser,   // is_october_first, range_error
    output int          mismatches,
    output int          outstanding
);

    localparam int YearW    = gdad_pkg::YearW;
    localparam int MonW     = gdad_pkg::MonW;
    localparam int DayW     = gdad_pkg::DayW;
    localparam int OffW     = gdad_pkg::OffW;
    localparam int MonLo    = YearW;
    localparam int DayLo    = YearW + MonW;
    localparam int OffLo    = YearW + MonW + DayW;
    localparam int LastDate = 3652058;   // day number of 9999-12-31

    typedef struct {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  mon;
        logic [DayW-1:0]  day;
        logic             oct_first;
        logic             range_err;
    } date_result_t;

    date_result_t dates_due[$];

    function automatic int month_days(input int yr, input int mo);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            2:       return leap ? 29 : 28;
            default: return 30;
        endcase
    endfunction

    // Date arithmetic through a day number counted from 0001-01-01.
    function automatic date_result_t add_days(input logic [YearW-1:0] y,
                                              input logic [MonW-1:0] m,
                                              input logic [DayW-1:0] d,
                                              input logic signed [OffW-1:0] off);
        date_result_t r;
        int yr, mo, dy, delta, n, c, f, o;
        yr = int'(y);
        mo = int'(m);
        dy = int'(d);
        delta = int'(off);
        if (delta > gdad_pkg::MaxOffset)
            delta = gdad_pkg::MaxOffset;
        if (delta < -gdad_pkg::MaxOffset)
            delta = -gdad_pkg::MaxOffset;
        r.year = y;
        r.mon = m;
        r.day = d;
        r.range_err = 1'b0;
        if (yr < 1 || yr > 9999 || mo < 1 || mo > 12 || dy < 1 || dy > month_days(yr, mo))
        begin
            r.range_err = 1'b1;
        end
        else
        begin
            n = 365 * (yr - 1) + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 + dy - 1;
            for (int k = 1; k < mo; k++)
                n += month_days(yr, k);
            n += delta;
            if (n < 0 || n > LastDate)
            begin
                r.range_err = 1'b1;
            end
            else
            begin
                yr = 400 * (n / 146097) + 1;
                n = n % 146097;
                c = n / 36524;
                if (c > 3)
                    c = 3;
                n -= c * 36524;
                f = n / 1461;
                n -= f * 1461;
                o = n / 365;
                if (o > 3)
                    o = 3;
                n -= o * 365;
                yr += 100 * c + 4 * f + o;
                mo = 1;
                while (mo < 12 && n >= month_days(yr, mo))
                begin
                    n -= month_days(yr, mo);
                    mo++;
                end
                r.year = YearW'(yr);
                r.mon = MonW'(mo);
                r.day = DayW'(n + 1);
            end
        end
        r.oct_first = (r.mon == gdad_pkg::MonOct) && (r.day == DayW'(1));
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        date_result_t want;
        if (!rst_n)
        begin
            dates_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (dates_due.size() == 0)
                begin
                    $error("result with no request waiting: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = dates_due.pop_front();
                    compare_field("result_year", 32'(want.year),
                                  32'(m_axis_tdata[MonLo-1:0]));
                    compare_field("result_month", 32'(want.mon),
                                  32'(m_axis_tdata[DayLo-1:MonLo]));
                    compare_field("result_day", 32'(want.day),
                                  32'(m_axis_tdata[OffLo-1:DayLo]));
                    compare_field("pad", 32'(0), 32'(m_axis_tdata[23]));
                    compare_field("is_october_first", 32'(want.oct_first),
                                  32'(m_axis_tuser[0]));
                    compare_field("range_error", 32'(want.range_err),
                                  32'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                dates_due.push_back(add_days(s_axis_tdata[MonLo-1:0],
                                             s_axis_tdata[DayLo-1:MonLo],
                                             s_axis_tdata[OffLo-1:DayLo],
                                             s_axis_tdata[39:OffLo]));
            outstanding <= dates_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int YearW = gdad_pkg::YearW;
    localparam int MonW  = gdad_pkg::MonW;
    localparam int DayW  = gdad_pkg::DayW;
    localparam int OffW  = gdad_pkg::OffW;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // start_year, start_month, start_day, day_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // result_year, result_month, result_day, zero pad
    logic [1:0]  m_axis_tuser;         // is_october_first, range_error

    int mismatches;
    int outstanding;

    // Sender-owned knobs: no_gaps drops idling on both sides, hold_req asks the
    // receiver for one long back-pressure stretch.
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    gregorian_date_add_days u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gdad_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offers one request after a random gap. tvalid is only lowered when a gap
    // is actually taken, so back-to-back requests keep it high across edges.
    task automatic send_date(input logic [YearW-1:0] y, input logic [MonW-1:0] m,
                             input logic [DayW-1:0] d, input logic signed [OffW-1:0] off);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off, d, m, y};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and wait until every predicted date has come back. The
    // first edge lets the checker's count catch the last accepted request.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver: random hold-off per result, plus one long stall on request.
    initial
    begin : receiver
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (hold_req && !hold_done)
            begin
                // long enough for the block to finish one more date behind
                // the full output register and push back on the input
                hold_done = 1'b1;
                gap = 3000;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Hard stop. Worst case is roughly 100 requests with at most ten stepping
    // the full 65535 days and the rest short; the timeout is several times that.
    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [YearW-1:0]       y;
        logic [MonW-1:0]        m;
        logic [DayW-1:0]        d;
        logic signed [OffW-1:0] off;
        int pick;
        int big_left;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: calendar corners, range limits, clamping, flags ----
        send_date(14'd2024, 4'd2, 5'd28, 17'sd1);         // into Feb 29, leap year
        send_date(14'd2023, 4'd2, 5'd28, 17'sd1);         // common year skips Feb 29
        send_date(14'd1900, 4'd2, 5'd28, 17'sd1);         // century, not leap
        send_date(14'd2000, 4'd2, 5'd28, 17'sd1);         // 400-year leap
        send_date(14'd2000, 4'd3, 5'd1, -17'sd1);         // back into Feb 29
        send_date(14'd1999, 4'd12, 5'd31, 17'sd1);        // year rollover
        send_date(14'd1, 4'd1, 5'd1, -17'sd1);            // underflow below year 1
        send_date(14'd9999, 4'd12, 5'd31, 17'sd1);        // overflow past 9999
        send_date(14'd9999, 4'd12, 5'd31, 17'sd0);        // last date, zero offset
        send_date(14'd2020, 4'd9, 5'd30, 17'sd1);         // lands on Oct 1
        send_date(14'd2021, 4'd10, 5'd1, 17'sd0);         // Oct 1 unchanged
        send_date(14'd2021, 4'd10, 5'd2, -17'sd1);        // back to Oct 1
        send_date(14'd0, 4'd10, 5'd1, 17'sd5);            // year 0: error, flag kept
        send_date(14'h3FFF, 4'hF, 5'h1F, 17'sd3);         // all-ones fields
        send_date(14'd2022, 4'd0, 5'd10, 17'sd3);         // month 0
        send_date(14'd2022, 4'd13, 5'd10, 17'sd3);        // month 13
        send_date(14'd2022, 4'd6, 5'd0, 17'sd3);          // day 0
        send_date(14'd2023, 4'd2, 5'd29, 17'sd1);         // Feb 29 in a common year
        send_date(14'd2023, 4'd4, 5'd31, -17'sd1);        // April 31
        send_date(14'd1, 4'd1, 5'd1, 17'sd65535);         // largest forward step
        send_date(14'd9999, 4'd12, 5'd31, 17'h10000);     // -65536 clamps to -65535
        send_date(14'd9990, 4'd1, 5'd1, 17'sd65535);      // overflow on a long step
        send_date(14'd10, 4'd6, 5'd15, -17'sd65535);      // underflow on a long step

        // pause until the pipeline is empty
        drain_results();

        // ---- back-pressure burst: receiver stalls, sender keeps offering ----
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (8)
        begin
            off = OffW'($urandom_range(0, 30));
            if ($urandom_range(0, 1))
                off = -off;
            send_date(YearW'($urandom_range(1, 9999)), MonW'($urandom_range(1, 12)),
                      DayW'($urandom_range(1, 28)), off);
        end
        no_gaps = 1'b0;

        // ---- random: mostly valid dates with short offsets, a few long ----
        big_left = 6;
        for (int i = 0; i < 70; i++)
        begin
            no_gaps = (i >= 40 && i < 55);
            pick = $urandom_range(0, 99);

            if (big_left > 0 && $urandom_range(0, 15) == 0)
            begin
                off = OffW'($urandom);
                big_left--;
            end
            else
            begin
                off = OffW'($urandom_range(0, 1500));
                if ($urandom_range(0, 1))
                    off = -off;
            end

            if (pick < 15)
            begin
                // noise: any bit pattern, mostly invalid dates
                y = YearW'($urandom);
                m = MonW'($urandom);
                d = DayW'($urandom);
            end
            else
            begin
                if (pick < 25)
                    y = ($urandom_range(0, 1)) ? YearW'($urandom_range(1, 4))
                                               : YearW'($urandom_range(9996, 9999));
                else
                    y = YearW'($urandom_range(1, 9999));
                m = MonW'($urandom_range(1, 12));
                // month ends now and then; some of these are invalid on purpose
                d = ($urandom_range(0, 3) == 0) ? DayW'($urandom_range(29, 31))
                                                : DayW'($urandom_range(1, 28));
            end
            send_date(y, m, d, off);
        end
        no_gaps = 1'b0;

        drain_results();
        // nothing is expected; watch a while for stray results
        repeat (500) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gdad_pkg.sv
src/gregorian_date_add_days.sv
bench/gdad_checker.sv
bench/tb_top.sv
